// ===== rtl/pswf_pkg.sv =====
// pswf_pkg: shared types and constants for the pencil sketch window filter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package pswf_pkg;

   // frame geometry
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);       // column index
   localparam int WIDTH_W    = 11;                      // image_width register
   localparam int HEIGHT_W   = 13;                      // image_height register
   localparam int CROW_W     = $clog2(MAX_HEIGHT);      // centre row index
   localparam int IROW_W     = HEIGHT_W;                // input row, may pass height

   // window geometry
   localparam int WIN_DIM    = 3;
   localparam int WIN_TAPS   = WIN_DIM * WIN_DIM;
   localparam int WIN_CENTRE = WIN_DIM + 1;

   // word layout: chan0 low byte, chan2 high byte
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int WORD_W     = CHAN_W * NUM_CHAN;

   // arithmetic widths
   localparam int BOX_W      = 12;   // sum of nine bytes
   localparam int GRAD_W     = 11;   // signed gradient sum
   localparam int GAIN_W     = 3;
   localparam int PROD_W     = 15;   // gain times box sum
   localparam int QUOT_W     = 12;   // quotient of a PROD_W value by nine

   // floor(x / 9) as (x * 7282) >> 16, exact for x below 32768
   localparam int DIV9_RECIP = 7282;
   localparam int DIV9_SHIFT = 16;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [WIDTH_W-1:0]  RST_WIDTH     = 11'd640;
   localparam logic [HEIGHT_W-1:0] RST_HEIGHT    = 13'd480;
   localparam logic [CHAN_W-1:0]   RST_THRESHOLD = 8'd25;
   localparam logic [CHAN_W-1:0]   RST_DARK      = 8'd32;
   localparam logic [GAIN_W-1:0]   RST_GAIN      = 3'd2;

   typedef enum logic [2:0] {
      REG_COLOR_MODE     = 3'd0,
      REG_IMAGE_WIDTH    = 3'd1,
      REG_IMAGE_HEIGHT   = 3'd2,
      REG_EDGE_THRESHOLD = 3'd3,
      REG_DARK_CUTOFF    = 3'd4,
      REG_GAIN           = 3'd5
   } reg_index_type;

   typedef logic [WORD_W-1:0] pix_word_type;
   typedef logic [WIN_TAPS-1:0][WORD_W-1:0] win_type;

   // border and end-of-frame marks for one window centre
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } pos_flags_type;

   // settings the arithmetic needs
   typedef struct packed {
      logic              color_mode;
      logic [CHAN_W-1:0] edge_threshold;
      logic [CHAN_W-1:0] dark_cutoff;
      logic [GAIN_W-1:0] gain;
   } kernel_cfg_type;

endpackage

// ===== rtl/pencil_sketch_window_filter.sv =====
// pencil_sketch_window_filter: top level with registers, raster counters and stage control
// depends on pswf_pkg, pswf_line_buf, pswf_window, pswf_kernel
//
//   channel   direction   handshake                       payload
//   req_      in          req_valid / req_ready           chan0, chan1, chan2, padding
//   rsp_      out         rsp_valid / rsp_ready           res0, res1, res2, frame_end
//   csr_      in/out      psel, penable, pwrite, pready   paddr[4:0], pwdata, prdata
//
// One word per clock while no held result stalls the stages. After acceptance a
// word passes the row store read, window shift, window sums and result registers in
// that order. A pixel's result leaves image_width + 1 words after that pixel enters.
// Reset clears counters, registers and stage valids; the row stores are not cleared.
// A held result stalls the stages behind it, and req_ready drops only then.
`timescale 1ns / 1ps

module pencil_sketch_window_filter (
   input  logic                               clock,
   input  logic                               reset,
   // input words
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_chan0,
   input  logic [7:0]                         req_chan1,
   input  logic [7:0]                         req_chan2,
   input  logic                               req_padding,
   // result words
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_res0,
   output logic [7:0]                         rsp_res1,
   output logic [7:0]                         rsp_res2,
   output logic                               rsp_frame_end,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pswf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pswf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pswf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   // registers
   logic                               color_mode_ff;
   logic [pswf_pkg::WIDTH_W-1:0]       image_width_ff;
   logic [pswf_pkg::HEIGHT_W-1:0]      image_height_ff;
   logic [pswf_pkg::CHAN_W-1:0]        edge_threshold_ff;
   logic [pswf_pkg::CHAN_W-1:0]        dark_cutoff_ff;
   logic [pswf_pkg::GAIN_W-1:0]        gain_ff;

   logic                               csr_wr;
   pswf_pkg::reg_index_type            csr_idx;
   logic                               restart;

   // raster counters
   logic [pswf_pkg::COL_W-1:0]         in_col_ff;
   logic [pswf_pkg::IROW_W-1:0]        in_row_ff;
   logic [pswf_pkg::COL_W-1:0]         ctr_col_ff;
   logic [pswf_pkg::CROW_W-1:0]        ctr_row_ff;

   logic [pswf_pkg::WIDTH_W-1:0]       w_eff;
   logic [pswf_pkg::HEIGHT_W-1:0]      h_eff;
   logic                               row_in_frame;
   logic                               ignore;
   logic                               acc;
   logic                               take;
   pswf_pkg::pix_word_type             pix;
   logic                               emit;
   logic [pswf_pkg::WIDTH_W-1:0]       in_col_nx;
   logic                               in_wrap;
   logic [pswf_pkg::WIDTH_W-1:0]       ctr_col_nx;
   logic [pswf_pkg::HEIGHT_W-1:0]      ctr_row_nx;
   pswf_pkg::pos_flags_type            pos;

   // read stage and window stage
   logic                               b_valid_ff, b_valid_in;
   pswf_pkg::pix_word_type             b_pix_ff;
   logic                               b_emit_ff;
   pswf_pkg::pos_flags_type            b_flags_ff;
   logic                               b_go;
   logic                               w_valid_ff, w_valid_in;
   pswf_pkg::pos_flags_type            w_flags_ff;
   logic                               w_free;
   logic                               win_ready;

   pswf_pkg::pix_word_type             up, mid;
   pswf_pkg::win_type                  win;
   pswf_pkg::kernel_cfg_type           kcfg;

   // register port decode
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = pswf_pkg::reg_index_type'(csr_paddr[4:2]);
   assign restart    = csr_wr && (csr_idx == pswf_pkg::REG_IMAGE_WIDTH ||
                                  csr_idx == pswf_pkg::REG_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff     <= 1'b0;
         image_width_ff    <= pswf_pkg::RST_WIDTH;
         image_height_ff   <= pswf_pkg::RST_HEIGHT;
         edge_threshold_ff <= pswf_pkg::RST_THRESHOLD;
         dark_cutoff_ff    <= pswf_pkg::RST_DARK;
         gain_ff           <= pswf_pkg::RST_GAIN;
      end else if (csr_wr) begin
         unique case (csr_idx)
            pswf_pkg::REG_COLOR_MODE:     color_mode_ff     <= csr_pwdata[0];
            pswf_pkg::REG_IMAGE_WIDTH:    image_width_ff    <= csr_pwdata[pswf_pkg::WIDTH_W-1:0];
            pswf_pkg::REG_IMAGE_HEIGHT:   image_height_ff   <= csr_pwdata[pswf_pkg::HEIGHT_W-1:0];
            pswf_pkg::REG_EDGE_THRESHOLD: edge_threshold_ff <= csr_pwdata[pswf_pkg::CHAN_W-1:0];
            pswf_pkg::REG_DARK_CUTOFF:    dark_cutoff_ff    <= csr_pwdata[pswf_pkg::CHAN_W-1:0];
            pswf_pkg::REG_GAIN:           gain_ff           <= csr_pwdata[pswf_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         pswf_pkg::REG_COLOR_MODE:     csr_prdata = pswf_pkg::CSR_DATA_W'(color_mode_ff);
         pswf_pkg::REG_IMAGE_WIDTH:    csr_prdata = pswf_pkg::CSR_DATA_W'(image_width_ff);
         pswf_pkg::REG_IMAGE_HEIGHT:   csr_prdata = pswf_pkg::CSR_DATA_W'(image_height_ff);
         pswf_pkg::REG_EDGE_THRESHOLD: csr_prdata = pswf_pkg::CSR_DATA_W'(edge_threshold_ff);
         pswf_pkg::REG_DARK_CUTOFF:    csr_prdata = pswf_pkg::CSR_DATA_W'(dark_cutoff_ff);
         pswf_pkg::REG_GAIN:           csr_prdata = pswf_pkg::CSR_DATA_W'(gain_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // effective geometry: zero acts as one, oversize saturates
   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = pswf_pkg::WIDTH_W'(1);
      end else if (image_width_ff > pswf_pkg::WIDTH_W'(pswf_pkg::MAX_WIDTH)) begin
         w_eff = pswf_pkg::WIDTH_W'(pswf_pkg::MAX_WIDTH);
      end else begin
         w_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         h_eff = pswf_pkg::HEIGHT_W'(1);
      end else if (image_height_ff > pswf_pkg::HEIGHT_W'(pswf_pkg::MAX_HEIGHT)) begin
         h_eff = pswf_pkg::HEIGHT_W'(pswf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = image_height_ff;
      end
   end

   // word classification at acceptance
   assign row_in_frame = in_row_ff < h_eff;
   assign ignore       = row_in_frame && req_padding;
   assign acc          = req_valid && req_ready;
   assign take         = acc && !ignore;
   assign pix          = row_in_frame ? {req_chan2, req_chan1, req_chan0} : '0;
   assign emit         = (in_row_ff >= pswf_pkg::IROW_W'(2)) ||
                         (in_row_ff == pswf_pkg::IROW_W'(1) && in_col_ff != '0);

   assign in_col_nx  = pswf_pkg::WIDTH_W'(in_col_ff) + pswf_pkg::WIDTH_W'(1);
   assign in_wrap    = in_col_nx >= w_eff;
   assign ctr_col_nx = pswf_pkg::WIDTH_W'(ctr_col_ff) + pswf_pkg::WIDTH_W'(1);
   assign ctr_row_nx = pswf_pkg::HEIGHT_W'(ctr_row_ff) + pswf_pkg::HEIGHT_W'(1);

   assign pos.top    = ctr_row_ff == '0;
   assign pos.bottom = ctr_row_nx >= h_eff;
   assign pos.left   = ctr_col_ff == '0;
   assign pos.right  = ctr_col_nx >= w_eff;
   assign pos.last   = emit && pos.bottom && pos.right;

   // raster counters
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         ctr_col_ff <= '0;
         ctr_row_ff <= '0;
      end else if (take) begin
         if (pos.last) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            ctr_col_ff <= '0;
            ctr_row_ff <= '0;
         end else begin
            if (emit) begin
               if (pos.right) begin
                  ctr_col_ff <= '0;
                  ctr_row_ff <= ctr_row_nx[pswf_pkg::CROW_W-1:0];
               end else begin
                  ctr_col_ff <= ctr_col_nx[pswf_pkg::COL_W-1:0];
               end
            end
            if (in_wrap) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + pswf_pkg::IROW_W'(1);
            end else begin
               in_col_ff <= in_col_nx[pswf_pkg::COL_W-1:0];
            end
         end
      end
   end

   // stage advance
   assign w_free    = !w_valid_ff || win_ready;
   assign b_go      = b_valid_ff && w_free;
   assign req_ready = !b_valid_ff || w_free;

   always_comb begin
      if (take) begin
         b_valid_in = 1'b1;
      end else if (b_go) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
      if (b_go) begin
         w_valid_in = b_emit_ff;
      end else if (win_ready) begin
         w_valid_in = 1'b0;
      end else begin
         w_valid_in = w_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         w_valid_ff <= w_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b_pix_ff   <= pix;
         b_emit_ff  <= emit;
         b_flags_ff <= pos;
      end
      if (b_go) begin
         w_flags_ff <= b_flags_ff;
      end
   end

   // row stores
   pswf_line_buf u_line_buf (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .col   (in_col_ff),
      .pix   (pix),
      .up    (up),
      .mid   (mid)
   );

   // window
   pswf_window u_window (
      .clock    (clock),
      .shift_en (b_go),
      .up       (up),
      .mid      (mid),
      .pix      (b_pix_ff),
      .win      (win)
   );

   assign kcfg.color_mode     = color_mode_ff;
   assign kcfg.edge_threshold = edge_threshold_ff;
   assign kcfg.dark_cutoff    = dark_cutoff_ff;
   assign kcfg.gain           = gain_ff;

   // filter arithmetic and result register
   pswf_kernel u_kernel (
      .clock         (clock),
      .reset         (reset),
      .win_valid     (w_valid_ff),
      .win_ready     (win_ready),
      .win           (win),
      .flags         (w_flags_ff),
      .cfg           (kcfg),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_res0      (rsp_res0),
      .rsp_res1      (rsp_res1),
      .rsp_res2      (rsp_res2),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== rtl/pswf_line_buf.sv =====
// pswf_line_buf: the two row stores that feed the window's right column
// depends on pswf_pkg
`timescale 1ns / 1ps

module pswf_line_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [pswf_pkg::COL_W-1:0]  col,
   input  pswf_pkg::pix_word_type      pix,
   output pswf_pkg::pix_word_type      up,
   output pswf_pkg::pix_word_type      mid
);

   pswf_pkg::pix_word_type upper_mem  [pswf_pkg::MAX_WIDTH];
   pswf_pkg::pix_word_type middle_mem [pswf_pkg::MAX_WIDTH];

   pswf_pkg::pix_word_type       up_ff;
   pswf_pkg::pix_word_type       mid_ff;
   logic                         wb_ff;
   logic [pswf_pkg::COL_W-1:0]   wb_col_ff;
   logic                         fwd;

   // a one-column frame reads the entry being written back this cycle
   assign fwd = wb_ff && (wb_col_ff == col);

   // middle row: read old word, store new pixel
   always_ff @(posedge clock) begin
      if (take) begin
         mid_ff          <= middle_mem[col];
         middle_mem[col] <= pix;
      end
   end

   // upper row: read, with bypass of the pending write-back
   always_ff @(posedge clock) begin
      if (take) begin
         up_ff <= fwd ? mid_ff : upper_mem[col];
      end
      if (wb_ff) begin
         upper_mem[wb_col_ff] <= mid_ff;
      end
   end

   // old middle word moves up in the cycle after the read
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff <= 1'b0;
      end else begin
         wb_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         wb_col_ff <= col;
      end
   end

   assign up  = up_ff;
   assign mid = mid_ff;

endmodule

// ===== rtl/pswf_window.sv =====
// pswf_window: 3x3 window registers, shifted left by one column per word
// depends on pswf_pkg
`timescale 1ns / 1ps

module pswf_window (
   input  logic                   clock,
   input  logic                   shift_en,
   input  pswf_pkg::pix_word_type up,
   input  pswf_pkg::pix_word_type mid,
   input  pswf_pkg::pix_word_type pix,
   output pswf_pkg::win_type      win
);

   pswf_pkg::win_type win_ff;
   pswf_pkg::win_type win_in;

   // shift each row left, new column enters on the right
   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < pswf_pkg::WIN_DIM; r++) begin
         for (int c = 0; c < pswf_pkg::WIN_DIM - 1; c++) begin
            win_in[r*pswf_pkg::WIN_DIM + c] = win_ff[r*pswf_pkg::WIN_DIM + c + 1];
         end
      end
      win_in[pswf_pkg::WIN_DIM - 1]       = up;
      win_in[2*pswf_pkg::WIN_DIM - 1]     = mid;
      win_in[pswf_pkg::WIN_TAPS - 1]      = pix;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff <= win_in;
      end
   end

   assign win = win_ff;

endmodule

// ===== rtl/pswf_kernel.sv =====
// pswf_kernel: window sums stage and result register stage
// depends on pswf_pkg
`timescale 1ns / 1ps

module pswf_kernel (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              win_valid,
   output logic                              win_ready,
   input  pswf_pkg::win_type                 win,
   input  pswf_pkg::pos_flags_type           flags,
   input  pswf_pkg::kernel_cfg_type          cfg,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pswf_pkg::CHAN_W-1:0]       rsp_res0,
   output logic [pswf_pkg::CHAN_W-1:0]       rsp_res1,
   output logic [pswf_pkg::CHAN_W-1:0]       rsp_res2,
   output logic                              rsp_frame_end
);

   localparam int PROD_MUL_W = pswf_pkg::PROD_W + pswf_pkg::DIV9_SHIFT;

   // floor division by nine through the reciprocal
   function automatic logic [pswf_pkg::QUOT_W-1:0] div9(
      input logic [pswf_pkg::PROD_W-1:0] x
   );
      logic [PROD_MUL_W-1:0] p;
      p = PROD_MUL_W'(x) * PROD_MUL_W'(pswf_pkg::DIV9_RECIP);
      return p[pswf_pkg::DIV9_SHIFT +: pswf_pkg::QUOT_W];
   endfunction

   // sums stage
   logic                                  s_valid_ff;
   logic                                  s_valid_in;
   logic [pswf_pkg::BOX_W-1:0]            s_box0_ff, s_box1_ff, s_box2_ff;
   logic [pswf_pkg::PROD_W-1:0]           s_prod_ff;
   logic signed [pswf_pkg::GRAD_W-1:0]    s_gmax_ff;
   logic                                  s_last_ff;

   // result stage
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic [pswf_pkg::CHAN_W-1:0]           res0_ff, res1_ff, res2_ff;
   logic                                  frame_end_ff;

   logic                                  r_free;
   logic                                  s_go;
   logic                                  s_load;

   pswf_pkg::pix_word_type                tap [pswf_pkg::WIN_TAPS];
   logic [pswf_pkg::BOX_W-1:0]            box0, box1, box2;
   logic signed [pswf_pkg::GRAD_W-1:0]    t [pswf_pkg::WIN_TAPS];
   logic signed [pswf_pkg::GRAD_W-1:0]    g1, g2, gmax;
   logic [pswf_pkg::PROD_W-1:0]           prod;

   logic [pswf_pkg::BOX_W-1:0]            thr9;
   logic                                  white;
   logic [pswf_pkg::PROD_W-1:0]           num0;
   logic [pswf_pkg::QUOT_W-1:0]           q0, q1, q2;
   logic [pswf_pkg::CHAN_W-1:0]           res0_in, res1_in, res2_in;

   // handshake between the stages
   assign r_free    = !rsp_valid_ff || rsp_ready;
   assign s_go      = s_valid_ff && r_free;
   assign win_ready = !s_valid_ff || r_free;
   assign s_load    = win_valid && win_ready;

   // border replacement and window sums
   always_comb begin
      for (int r = 0; r < pswf_pkg::WIN_DIM; r++) begin
         for (int c = 0; c < pswf_pkg::WIN_DIM; c++) begin
            if ((r == 0 && flags.top) || (r == pswf_pkg::WIN_DIM - 1 && flags.bottom) ||
                (c == 0 && flags.left) || (c == pswf_pkg::WIN_DIM - 1 && flags.right)) begin
               tap[r*pswf_pkg::WIN_DIM + c] = win[pswf_pkg::WIN_CENTRE];
            end else begin
               tap[r*pswf_pkg::WIN_DIM + c] = win[r*pswf_pkg::WIN_DIM + c];
            end
         end
      end
      box0 = '0;
      box1 = '0;
      box2 = '0;
      for (int i = 0; i < pswf_pkg::WIN_TAPS; i++) begin
         box0 = box0 + pswf_pkg::BOX_W'(tap[i][0 +: pswf_pkg::CHAN_W]);
         box1 = box1 + pswf_pkg::BOX_W'(tap[i][pswf_pkg::CHAN_W +: pswf_pkg::CHAN_W]);
         box2 = box2 + pswf_pkg::BOX_W'(tap[i][2*pswf_pkg::CHAN_W +: pswf_pkg::CHAN_W]);
         t[i] = $signed(pswf_pkg::GRAD_W'(tap[i][0 +: pswf_pkg::CHAN_W]));
      end
   end

   // diagonal gradients on the gray byte, centre has weight zero
   assign g1   = t[0] + t[1] - t[2] + t[3] - t[5] + t[6] - t[7] - t[8];
   assign g2   = t[0] + t[1] + t[2] - t[3] + t[5] - t[6] - t[7] - t[8];
   assign gmax = (g1 > g2) ? g1 : g2;
   assign prod = {3'b000, box0} * pswf_pkg::PROD_W'(cfg.gain);

   always_comb begin
      if (s_load) begin
         s_valid_in = 1'b1;
      end else if (s_go) begin
         s_valid_in = 1'b0;
      end else begin
         s_valid_in = s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s_load) begin
         s_box0_ff <= box0;
         s_box1_ff <= box1;
         s_box2_ff <= box2;
         s_prod_ff <= prod;
         s_gmax_ff <= gmax;
         s_last_ff <= flags.last;
      end
   end

   // edge test, scaling, clamping and per-channel averages
   assign thr9  = (pswf_pkg::BOX_W'(cfg.edge_threshold) << 3) +
                  pswf_pkg::BOX_W'(cfg.edge_threshold);
   assign white = s_gmax_ff[pswf_pkg::GRAD_W-1] ||
                  ({1'b0, s_gmax_ff[pswf_pkg::GRAD_W-2:0]} < thr9);
   assign num0  = cfg.color_mode ? pswf_pkg::PROD_W'(s_box0_ff) : s_prod_ff;
   assign q0    = div9(num0);
   assign q1    = div9(pswf_pkg::PROD_W'(s_box1_ff));
   assign q2    = div9(pswf_pkg::PROD_W'(s_box2_ff));

   always_comb begin
      if (cfg.color_mode) begin
         res0_in = q0[pswf_pkg::CHAN_W-1:0];
         res1_in = q1[pswf_pkg::CHAN_W-1:0];
         res2_in = q2[pswf_pkg::CHAN_W-1:0];
      end else begin
         res1_in = '0;
         res2_in = '0;
         if (white) begin
            res0_in = '1;
         end else if (q0 > pswf_pkg::QUOT_W'(8'hFF)) begin
            res0_in = '0;
         end else if (q0[pswf_pkg::CHAN_W-1:0] < cfg.dark_cutoff) begin
            res0_in = '1;
         end else begin
            res0_in = 8'hFF - q0[pswf_pkg::CHAN_W-1:0];
         end
      end
   end

   always_comb begin
      if (s_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s_go) begin
         res0_ff      <= res0_in;
         res1_ff      <= res1_in;
         res2_ff      <= res2_in;
         frame_end_ff <= s_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res0      = res0_ff;
   assign rsp_res1      = res1_ff;
   assign rsp_res2      = res2_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// ===== rtl/pswf_checker.sv =====
// pswf_checker: port-level checks for the pencil sketch window filter
// depends on pencil_sketch_window_filter ports; attached by the bind below
`timescale 1ns / 1ps

module pswf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_res0,
   input logic [7:0] rsp_res1,
   input logic [7:0] rsp_res2,
   input logic       rsp_frame_end
);

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // input is back-pressured only by a held result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while output is free");

   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_res0) && $stable(rsp_res1) && $stable(rsp_res2) &&
          $stable(rsp_frame_end)))
      else $error("result payload changed while stalled");

endmodule

bind pencil_sketch_window_filter pswf_checker u_pswf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_res0      (rsp_res0),
   .rsp_res1      (rsp_res1),
   .rsp_res2      (rsp_res2),
   .rsp_frame_end (rsp_frame_end)
);

// ===== dv/pencil_sketch_window_filter_tb.sv =====
// pencil_sketch_window_filter_tb: self-checking bench for the 3x3 sketch filter
// predicts every result word from a cycle-free model of the window and row stores
// depends on pswf_pkg and the pencil_sketch_window_filter top level
`timescale 1ns / 1ps

import pswf_pkg::*;

typedef struct packed {
   logic [7:0] res0;
   logic [7:0] res1;
   logic [7:0] res2;
   logic       frame_end;
} sketch_result_t;

// predicted filter state and the queue of result words still owed by the block
class sketch_scoreboard;
   logic                color_mode;
   logic [WIDTH_W-1:0]  image_width;
   logic [HEIGHT_W-1:0] image_height;
   logic [CHAN_W-1:0]   edge_threshold;
   logic [CHAN_W-1:0]   dark_cutoff;
   logic [GAIN_W-1:0]   gain;
   pix_word_type        row_above[MAX_WIDTH];
   pix_word_type        row_middle[MAX_WIDTH];
   pix_word_type        window_taps[WIN_TAPS];
   int unsigned         in_col, in_row, centre_col, centre_row;
   sketch_result_t      awaited[$];
   int unsigned         mismatches;

   function new();
      color_mode     = 1'b0;
      image_width    = RST_WIDTH;
      image_height   = RST_HEIGHT;
      edge_threshold = RST_THRESHOLD;
      dark_cutoff    = RST_DARK;
      gain           = RST_GAIN;
      foreach (row_above[i]) begin
         row_above[i]  = '0;
         row_middle[i] = '0;
      end
      foreach (window_taps[i]) window_taps[i] = '0;
      mismatches = 0;
      restart();
   endfunction

   function void restart();
      in_col     = 0;
      in_row     = 0;
      centre_col = 0;
      centre_row = 0;
   endfunction

   // geometry as the block sees it, out-of-range values clamped
   function int unsigned frame_w();
      if (image_width == 0) return 1;
      if (image_width > MAX_WIDTH) return MAX_WIDTH;
      return image_width;
   endfunction

   function int unsigned frame_h();
      if (image_height == 0) return 1;
      if (image_height > MAX_HEIGHT) return MAX_HEIGHT;
      return image_height;
   endfunction

   function int unsigned pending();
      return awaited.size();
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
         REG_COLOR_MODE:     color_mode = value[0];
         REG_IMAGE_WIDTH: begin
            image_width = value[WIDTH_W-1:0];
            restart();
         end
         REG_IMAGE_HEIGHT: begin
            image_height = value[HEIGHT_W-1:0];
            restart();
         end
         REG_EDGE_THRESHOLD: edge_threshold = value[CHAN_W-1:0];
         REG_DARK_CUTOFF:    dark_cutoff = value[CHAN_W-1:0];
         REG_GAIN:           gain = value[GAIN_W-1:0];
         default: ;
      endcase
   endfunction

   // one channel byte of a window position, border taps take the centre
   function int tap_value(int r, int c, int ch, int unsigned w, int unsigned h);
      pix_word_type word;
      logic         outside;
      outside = (r == 0 && centre_row == 0) || (r == 2 && centre_row + 1 >= h) ||
                (c == 0 && centre_col == 0) || (c == 2 && centre_col + 1 >= w);
      word = outside ? window_taps[WIN_CENTRE] : window_taps[r*WIN_DIM + c];
      return int'(word[ch*CHAN_W +: CHAN_W]);
   endfunction

   function int channel_sum(int ch, int unsigned w, int unsigned h);
      int total;
      total = 0;
      for (int r = 0; r < WIN_DIM; r++)
         for (int c = 0; c < WIN_DIM; c++)
            total += tap_value(r, c, ch, w, h);
      return total;
   endfunction

   // gray path: white on flat areas, else inverted and scaled box average
   function logic [7:0] sketch_level(int unsigned w, int unsigned h);
      int          t[WIN_DIM][WIN_DIM];
      int          grad_a, grad_b, steep;
      int unsigned scaled;
      for (int r = 0; r < WIN_DIM; r++)
         for (int c = 0; c < WIN_DIM; c++)
            t[r][c] = tap_value(r, c, 0, w, h);
      grad_a = t[0][0] + t[0][1] - t[0][2] + t[1][0] - t[1][2] + t[2][0] - t[2][1] - t[2][2];
      grad_b = t[0][0] + t[0][1] + t[0][2] - t[1][0] + t[1][2] - t[2][0] - t[2][1] - t[2][2];
      steep = (grad_a > grad_b) ? grad_a : grad_b;
      if (steep < 9 * int'(edge_threshold)) return 8'd255;
      scaled = (int'(gain) * channel_sum(0, w, h)) / 9;
      if (scaled > 255) scaled = 255;
      else if (scaled < dark_cutoff) scaled = 0;
      return 8'(255 - scaled);
   endfunction

   // accepted input word: advance the stores and window, queue any result
   function void note_word(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic pad);
      int unsigned    w, h;
      pix_word_type   pix, above, middle;
      sketch_result_t word;
      w = frame_w();
      h = frame_h();
      if (in_row < h && pad) return;
      pix = (in_row < h) ? {c2, c1, c0} : '0;

      above  = row_above[in_col];
      middle = row_middle[in_col];
      row_above[in_col]  = middle;
      row_middle[in_col] = pix;

      for (int r = 0; r < WIN_DIM; r++) begin
         window_taps[r*WIN_DIM]     = window_taps[r*WIN_DIM + 1];
         window_taps[r*WIN_DIM + 1] = window_taps[r*WIN_DIM + 2];
      end
      window_taps[2]           = above;
      window_taps[WIN_DIM + 2]   = middle;
      window_taps[2*WIN_DIM + 2] = pix;

      if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
         word.frame_end = (centre_row + 1 >= h) && (centre_col + 1 >= w);
         if (color_mode) begin
            word.res0 = 8'(channel_sum(0, w, h) / 9);
            word.res1 = 8'(channel_sum(1, w, h) / 9);
            word.res2 = 8'(channel_sum(2, w, h) / 9);
         end else begin
            word.res0 = sketch_level(w, h);
            word.res1 = 8'd0;
            word.res2 = 8'd0;
         end
         awaited.push_back(word);
         if (word.frame_end) begin
            restart();
            return;
         end
         centre_col++;
         if (centre_col >= w) begin
            centre_col = 0;
            centre_row++;
         end
      end

      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
   endfunction

   // result word from the block against the oldest prediction
   function void check_word(sketch_result_t got);
      sketch_result_t want;
      if (awaited.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result word res0=%0d res1=%0d res2=%0d frame_end=%0b",
                     $time, got.res0, got.res1, got.res2, got.frame_end);
         return;
      end
      want = awaited.pop_front();
      if (got.res0 !== want.res0 || got.res1 !== want.res1 || got.res2 !== want.res2 ||
          got.frame_end !== want.frame_end) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result mismatch expected %0d/%0d/%0d end=%0b got %0d/%0d/%0d end=%0b",
                     $time, want.res0, want.res1, want.res2, want.frame_end,
                     got.res0, got.res1, got.res2, got.frame_end);
      end
   endfunction
endclass

module pencil_sketch_window_filter_tb;

   localparam logic [2:0] REG_SPARE_LO  = 3'd6;
   localparam logic [2:0] REG_SPARE_HI  = 3'd7;
   localparam int         TARGET_WORDS  = 650;
   localparam int         HOLD_CYCLES   = 200;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         DRAIN_CYCLES  = 20;
   localparam int         STALL_LIMIT   = 4000;

   typedef enum {FILL_NOISE, FILL_FLAT, FILL_BINARY, FILL_RAMP} fill_kind_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_chan0, req_chan1, req_chan2;
   logic                  req_padding;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_res0, rsp_res1, rsp_res2;
   logic                  rsp_frame_end;
   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sketch_scoreboard      sketch_tracker;
   bit                    idle_on = 1'b1;
   logic                  hold_request;
   int unsigned           words_sent = 0;
   int unsigned           quiet_cycles = 0;

   pencil_sketch_window_filter uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_chan0     (req_chan0),
      .req_chan1     (req_chan1),
      .req_chan2     (req_chan2),
      .req_padding   (req_padding),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_res0      (rsp_res0),
      .rsp_res1      (rsp_res1),
      .rsp_res2      (rsp_res2),
      .rsp_frame_end (rsp_frame_end),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // one input word, with random idle cycles ahead of it
   task automatic drive_word(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic pad);
      int gap = 0;
      while (idle_on && $urandom_range(99) < 36) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_chan0   <= c0;
      req_chan1   <= c1;
      req_chan2   <= c2;
      req_padding <= pad;
      do @(posedge clock); while (!req_ready);
      sketch_tracker.note_word(c0, c1, c2, pad);
   endtask

   // register write once every owed result is out and the stages are empty
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      req_valid <= 1'b0;
      while (sketch_tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sketch_tracker.write_reg(idx, value);
   endtask

   task automatic load_settings(logic mode, int unsigned w, int unsigned h, int unsigned thr,
                                int unsigned dark, int unsigned g);
      csr_write(REG_COLOR_MODE, 32'(mode));
      csr_write(REG_IMAGE_WIDTH, 32'(w));
      csr_write(REG_IMAGE_HEIGHT, 32'(h));
      csr_write(REG_EDGE_THRESHOLD, 32'(thr));
      csr_write(REG_DARK_CUTOFF, 32'(dark));
      csr_write(REG_GAIN, 32'(g));
   endtask

   // pixel content shapes: noise, near-flat, black/white, column ramp
   function automatic logic [7:0] fill_byte(fill_kind_t fill, logic [7:0] base, int unsigned k);
      int v;
      case (fill)
         FILL_FLAT: begin
            v = int'(base) + int'($urandom_range(6)) - 3;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
         FILL_BINARY: v = $urandom_range(1) ? 255 : 0;
         FILL_RAMP:   v = (int'(base) + int'(k) * 23) % 256;
         default:     v = int'($urandom_range(255));
      endcase
      return 8'(v);
   endfunction

   // pixels with stray padding among them, then drain words, some of them pixels
   task automatic send_frame(int unsigned pixels, int unsigned drains, fill_kind_t fill,
                             logic [7:0] base);
      for (int unsigned k = 0; k < pixels; k++) begin
         if ($urandom_range(19) == 0)
            drive_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
         drive_word(fill_byte(fill, base, k), fill_byte(fill, base + 8'd40, k),
                    fill_byte(fill, base + 8'd90, k), 1'b0);
         words_sent++;
      end
      for (int unsigned k = 0; k < drains; k++) begin
         drive_word(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(4) != 0);
         words_sent++;
      end
   endtask

   // result side: check each accepted word, then pick next ready
   initial begin
      sketch_result_t got;
      int             hold_left = 0;
      bit             hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.res0      = rsp_res0;
            got.res1      = rsp_res1;
            got.res2      = rsp_res2;
            got.frame_end = rsp_frame_end;
            sketch_tracker.check_word(got);
         end
         if (hold_request === 1'b1 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 36);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("pencil_sketch_window_filter test failed");
      $finish;
   end

   // stimulus and end of run
   initial begin
      logic [7:0]  corner_frame[9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255,
                                       8'd0, 8'd0, 8'd255};
      fill_kind_t  fill;
      logic [7:0]  base;
      logic        mode;
      int unsigned w, h, fw, fh, phase;

      sketch_tracker = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_chan0    <= 8'd0;
      req_chan1    <= 8'd0;
      req_chan2    <= 8'd0;
      req_padding  <= 1'b0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      hold_request <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // writes to unused addresses change nothing
      csr_write(REG_SPARE_LO, $urandom);
      csr_write(REG_SPARE_HI, $urandom);

      // gray 3x3 with hard edges, a stray padding word and a pixel while draining
      load_settings(1'b0, 3, 3, 0, 200, 1);
      for (int k = 0; k < 9; k++) begin
         if (k == 2) drive_word(8'hFF, 8'hFF, 8'hFF, 1'b1);
         drive_word(corner_frame[k], 8'($urandom), 8'($urandom), 1'b0);
      end
      repeat (3) drive_word(8'd0, 8'd0, 8'd0, 1'b1);
      drive_word(8'hFF, 8'hFF, 8'hFF, 1'b0);

      // zero geometry acts as 1x1, a gain of four clamps the product
      load_settings(1'b0, 0, 0, 0, 0, 4);
      drive_word(8'd200, 8'd0, 8'd0, 1'b0);
      repeat (2) drive_word(8'd0, 8'd0, 8'd0, 1'b1);

      // colour 2x2 with channel extremes
      load_settings(1'b1, 2, 2, 25, 32, 2);
      drive_word(8'hFF, 8'h00, 8'hFF, 1'b0);
      drive_word(8'h00, 8'hFF, 8'h00, 1'b0);
      drive_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
      drive_word(8'h00, 8'h00, 8'h00, 1'b0);
      repeat (3) drive_word(8'd0, 8'd0, 8'd0, 1'b1);

      // largest geometry, cut short by the next geometry write
      load_settings(1'b0, MAX_WIDTH, MAX_HEIGHT, 255, 255, 7);
      drive_word(8'd17, 8'd34, 8'd51, 1'b0);
      drive_word(8'd68, 8'd85, 8'd102, 1'b0);

      // oversized width saturates to a full row
      load_settings(1'($urandom_range(1)), 2047, 1, 20, 40, 2);
      send_frame(MAX_WIDTH, MAX_WIDTH + 1, FILL_RAMP, 8'($urandom));

      // oversized height saturates, one column, no idling on either side
      idle_on = 1'b0;
      load_settings(1'b0, 1, 8191, 30, 64, 3);
      send_frame(MAX_HEIGHT, 2, FILL_NOISE, 8'($urandom));
      idle_on = 1'b1;

      // random settings and frames, mostly small
      words_sent = 0;
      phase = 0;
      while (words_sent < TARGET_WORDS) begin
         idle_on = (phase % 6 != 4);
         mode = 1'($urandom_range(1));
         w = ($urandom_range(9) < 7) ? $urandom_range(8) : $urandom_range(40, 9);
         h = $urandom_range(6);
         if (phase == 1) begin
            w = 5;
            h = 6;
         end
         load_settings(mode, w, h, $urandom_range(1) ? $urandom_range(40) : $urandom_range(255),
                       $urandom_range(255),
                       ($urandom_range(4) == 0) ? $urandom_range(7) : $urandom_range(4, 1));
         fw = (w == 0) ? 1 : w;
         fh = (h == 0) ? 1 : h;
         fill = fill_kind_t'($urandom_range(3));
         base = 8'($urandom);
         if (phase == 1) begin
            // results back up behind a stalled receiver
            hold_request <= 1'b1;
            repeat (2) send_frame(fw * fh, fw + 1, fill, base);
         end else if (phase == 2) begin
            // sender waits mid-frame for every owed result
            send_frame(fw * fh / 2, 0, fill, base);
            req_valid <= 1'b0;
            @(posedge clock);
            while (sketch_tracker.pending() != 0) @(posedge clock);
            send_frame(fw * fh - fw * fh / 2, fw + 1, fill, base);
         end else if ($urandom_range(9) == 0) begin
            // broken frame, restarted by the next settings
            send_frame($urandom_range(fw * fh), 0, fill, base);
         end else begin
            repeat ($urandom_range(2, 1)) send_frame(fw * fh, fw + 1, fill, base);
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (sketch_tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sketch_tracker.mismatches == 0 && sketch_tracker.pending() == 0)
         $display("pencil_sketch_window_filter test passed");
      else
         $display("pencil_sketch_window_filter test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pswf_pkg.sv
rtl/pswf_line_buf.sv
rtl/pswf_window.sv
rtl/pswf_kernel.sv
rtl/pencil_sketch_window_filter.sv
rtl/pswf_checker.sv
dv/pencil_sketch_window_filter_tb.sv
